/* rtl/core/sorted_priority_queue_macros.svh */
// Assertion helpers for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define SPQ_ASSERT_IMP(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Check that a condition implies another in the next cycle
`define SPQ_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

/* rtl/core/spq_pkg.sv */
`default_nettype none
package spq_pkg;
    localparam int unsigned CapacityDefault = 16;

    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_TOP  = 2'd2,
        FUNC_INC  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_NOT_HIGHER = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_LE = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;
    localparam logic [1:0] ORD_GE = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
        logic signed [31:0] priority_req;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic signed [31:0] out_priority;
        logic signed [31:0] old_priority;
        logic [2:0]         status;
        logic               now_empty;
    } t_out_word;

    // Command broadcast to every cell in the chain
    typedef struct packed {
        logic               insert;   // insert new pair at its sorted place
        logic               remove;   // remove the entry flagged as target
        logic               rm_head;  // target is the head entry
        logic signed [31:0] value;
        logic signed [31:0] prio;
        logic [1:0]         order;
    } t_cell_cmd;

    // a beats b under the order relation
    function automatic logic beats(input logic [1:0] order,
                                   input logic signed [31:0] a,
                                   input logic signed [31:0] b);
        logic r;
        begin
            case (order)
                ORD_LT:  r = a < b;
                ORD_LE:  r = a <= b;
                ORD_GT:  r = a > b;
                default: r = a >= b;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/core/sorted_priority_queue.sv */
`default_nettype none
// Sorted priority queue of CAPACITY (value, priority) entries held in a row of
// cells, head at cell 0. An accepted word runs an evaluate step, in which all
// cells evaluate in parallel (match and beat flags ripple along the row) and
// the row shifts at its end, then a result step that registers the result
// word. A successful priority increase runs removal, insertion and result steps.
// One word is in work at a time; a result held by i_stall blocks the next
// word. order_mode (APB address 0, reset 1) selects the relation by which a
// new priority beats a stored one; write it only while idle.
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = spq_pkg::CapacityDefault
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire spq_pkg::t_in_word  i_data,
    output logic                    o_valid,
    input  wire                     i_stall,
    output spq_pkg::t_out_word      o_data,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire [1:0]               paddr,
    input  wire [31:0]              pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import spq_pkg::*;
    `include "sorted_priority_queue_macros.svh"

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_INS, S_DONE} t_state;

    t_state             r_state;
    t_state             n_state;
    t_in_word           r_in;
    t_in_word           n_in;
    t_out_word          r_out;
    t_out_word          n_out;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [1:0]         r_order;
    t_cell_cmd          w_cmd;
    logic               w_step;
    logic               w_head_valid, w_full, w_found, w_empty;
    logic signed [31:0] w_head_value, w_head_prio, w_found_prio;

    assign pready = 1'b1;
    assign prdata = {30'd0, r_order};

    // config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORD_LE;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_order <= pwdata[1:0];
        end
    end

    // drive the cell command from the latched word
    always_comb begin
        w_cmd       = '0;
        w_cmd.order = r_order;
        w_cmd.value = r_in.value;
        w_cmd.prio  = r_in.priority_req;
        w_step      = 1'b0;
        if (r_state == S_EVAL) begin
            w_step = 1'b1;
            unique case (t_func'(r_in.func))
                FUNC_PUSH: w_cmd.insert = !w_full;
                FUNC_POP: begin
                    w_cmd.remove  = 1'b1;
                    w_cmd.rm_head = 1'b1;
                end
                FUNC_TOP: w_cmd.remove = 1'b0;
                FUNC_INC: w_cmd.remove = w_found &&
                                         beats(r_order, r_in.priority_req, w_found_prio);
                default: w_cmd.remove = 1'b0;
            endcase
        end else if (r_state == S_INS) begin
            w_step       = 1'b1;
            w_cmd.insert = 1'b1;
        end
    end

    spq_chain #(.CAPACITY(CAPACITY)) u_chain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_step        (w_step),
        .o_head_valid  (w_head_valid),
        .o_head_value  (w_head_value),
        .o_head_prio   (w_head_prio),
        .o_full        (w_full),
        .o_found       (w_found),
        .o_found_prio  (w_found_prio),
        .o_after_empty (w_empty)
    );

    // hold off a new word while busy or while a result word is still waiting
    assign o_stall = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // sequencer next state and result word
    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        // drop the result word once taken
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_in    = i_data;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_out   = '0;
                n_state = S_DONE;
                unique case (t_func'(r_in.func))
                    FUNC_PUSH: if (w_full) n_out.status = ST_FULL;
                    FUNC_POP, FUNC_TOP: begin
                        if (!w_head_valid) begin
                            n_out.status = ST_EMPTY;
                        end else begin
                            n_out.out_value    = w_head_value;
                            n_out.out_priority = w_head_prio;
                        end
                    end
                    FUNC_INC: begin
                        if (!w_found) begin
                            n_out.status       = ST_NOT_FOUND;
                            n_out.old_priority = -32'sd1;
                        end else begin
                            n_out.old_priority = w_found_prio;
                            if (!beats(r_order, r_in.priority_req, w_found_prio))
                                n_out.status = ST_NOT_HIGHER;
                            else
                                n_state = S_INS;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_INS: n_state = S_DONE;
            S_DONE: begin
                n_out.now_empty = w_empty;
                n_out_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_in  <= n_in;
        r_out <= n_out;
    end

    `SPQ_ASSERT_NEXT(a_pop_empty_flags, i_clk, i_rst_n,
        r_state == S_EVAL && r_in.func == FUNC_POP && !w_head_valid, r_out.status == ST_EMPTY)
    `SPQ_ASSERT_IMP(a_full_not_insert, i_clk, i_rst_n, w_full, !(w_cmd.insert && r_state == S_EVAL))
    `SPQ_ASSERT_NEXT(a_done_gives_word, i_clk, i_rst_n, r_state == S_DONE, o_valid)
endmodule
`default_nettype wire

/* rtl/core/spq_cell.sv */
`default_nettype none
// One slot of the sorted chain. Apart from the broadcast command, cells talk only to neighbors.
module spq_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire spq_pkg::t_cell_cmd  i_cmd,
    input  wire                      i_step,
    // left neighbor (toward head)
    input  wire                      i_l_valid,
    input  wire                      i_l_beaten,
    input  wire                      i_l_hit,
    input  wire signed [31:0]        i_l_value,
    input  wire signed [31:0]        i_l_prio,
    // right neighbor (toward tail)
    input  wire                      i_r_valid,
    input  wire signed [31:0]        i_r_value,
    input  wire signed [31:0]        i_r_prio,
    // own state to neighbors
    output logic                     o_valid,
    output logic                     o_beaten,
    output logic                     o_hit,
    output logic signed [31:0]       o_value,
    output logic signed [31:0]       o_prio
);
    import spq_pkg::*;

    logic               r_valid;
    logic signed [31:0] r_value;
    logic signed [31:0] r_prio;
    logic               n_valid;
    logic signed [31:0] n_value;
    logic signed [31:0] n_prio;
    logic               w_beat;
    logic               w_match;

    // new pair beats this entry; prefix-OR makes the insert point
    assign w_beat   = r_valid && beats(i_cmd.order, i_cmd.prio, r_prio);
    assign o_beaten = i_l_beaten || w_beat;
    // search hit: valid entry with matching value; prefix-OR marks the first hit onward
    assign w_match  = r_valid && (r_value == i_cmd.value);
    assign o_hit    = i_l_hit || w_match;
    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_prio   = r_prio;

    // shift toward tail on insert, toward head from the hit entry (or from the head on rm_head) on remove
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_prio  = r_prio;
        if (i_cmd.remove && (i_l_hit || w_match || i_cmd.rm_head)) begin
            n_valid = i_r_valid;
            n_value = i_r_value;
            n_prio  = i_r_prio;
        end else if (i_cmd.insert) begin
            if (i_l_beaten) begin
                n_valid = i_l_valid;
                n_value = i_l_value;
                n_prio  = i_l_prio;
            end else if (w_beat || (!r_valid && i_l_valid)) begin
                n_valid = 1'b1;
                n_value = i_cmd.value;
                n_prio  = i_cmd.prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_value <= n_value;
            r_prio  <= n_prio;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/spq_chain.sv */
`default_nettype none
// Row of cells with head and tail boundary conditions.
module spq_chain #(
    parameter int unsigned CAPACITY = spq_pkg::CapacityDefault
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire spq_pkg::t_cell_cmd  i_cmd,
    input  wire                      i_step,
    output logic                     o_head_valid,
    output logic signed [31:0]       o_head_value,
    output logic signed [31:0]       o_head_prio,
    output logic                     o_full,
    output logic                     o_found,
    output logic signed [31:0]       o_found_prio,
    output logic                     o_after_empty
);
    import spq_pkg::*;

    logic               w_valid  [CAPACITY];
    logic               w_beaten [CAPACITY];
    logic               w_hit    [CAPACITY];
    logic signed [31:0] w_value  [CAPACITY];
    logic signed [31:0] w_prio   [CAPACITY];
    logic signed [31:0] w_fprio  [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic               l_valid, l_beaten, l_hit, r_valid_in;
            logic signed [31:0] l_value, l_prio, r_value_in, r_prio_in;
            if (g == 0) begin : g_head
                // head sees an always-valid, never-beaten left neighbor
                assign l_valid  = 1'b1;
                assign l_beaten = 1'b0;
                assign l_hit    = 1'b0;
                assign l_value  = '0;
                assign l_prio   = '0;
            end else begin : g_body
                assign l_valid  = w_valid[g-1];
                assign l_beaten = w_beaten[g-1];
                assign l_hit    = w_hit[g-1];
                assign l_value  = w_value[g-1];
                assign l_prio   = w_prio[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign r_valid_in = 1'b0;
                assign r_value_in = '0;
                assign r_prio_in  = '0;
            end else begin : g_inner
                assign r_valid_in = w_valid[g+1];
                assign r_value_in = w_value[g+1];
                assign r_prio_in  = w_prio[g+1];
            end
            spq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (i_cmd),
                .i_step     (i_step),
                .i_l_valid  (l_valid),
                .i_l_beaten (l_beaten),
                .i_l_hit    (l_hit),
                .i_l_value  (l_value),
                .i_l_prio   (l_prio),
                .i_r_valid  (r_valid_in),
                .i_r_value  (r_value_in),
                .i_r_prio   (r_prio_in),
                .o_valid    (w_valid[g]),
                .o_beaten   (w_beaten[g]),
                .o_hit      (w_hit[g]),
                .o_value    (w_value[g]),
                .o_prio     (w_prio[g])
            );
            // carry priority of first hit along the chain
            if (g == 0) begin : g_f0
                assign w_fprio[g] = w_prio[g];
            end else begin : g_fn
                assign w_fprio[g] = w_hit[g-1] ? w_fprio[g-1] : w_prio[g];
            end
        end
    endgenerate

    assign o_head_valid  = w_valid[0];
    assign o_head_value  = w_value[0];
    assign o_head_prio   = w_prio[0];
    assign o_full        = w_valid[CAPACITY-1];
    assign o_found       = w_hit[CAPACITY-1];
    assign o_found_prio  = w_fprio[CAPACITY-1];
    // after settle: empty when head cell holds nothing
    assign o_after_empty = !w_valid[0];
endmodule
`default_nettype wire

/* bench/sorted_priority_queue_test.sv */
`default_nettype none
module sorted_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;
    import spq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 1700;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in_word i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out_word o_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    sorted_priority_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the queue contents and the order relation
    logic signed [31:0] q_vals [DEPTH];
    logic signed [31:0] q_pris [DEPTH];
    int q_count;
    logic [1:0] q_order;

    t_out_word pending_results [$];
    int mismatches;
    int cycles;
    bit all_sent;

    function automatic bit outranks(logic signed [31:0] a, logic signed [31:0] b);
        case (q_order)
            ORD_LT:  return a < b;
            ORD_LE:  return a <= b;
            ORD_GT:  return a > b;
            default: return a >= b;
        endcase
    endfunction

    function automatic void place_entry(logic signed [31:0] v, logic signed [31:0] p);
        int pos;
        pos = 0;
        while (pos < q_count && !outranks(p, q_pris[pos])) pos++;
        for (int k = q_count; k > pos; k--) begin
            q_vals[k] = q_vals[k-1];
            q_pris[k] = q_pris[k-1];
        end
        q_vals[pos] = v;
        q_pris[pos] = p;
        q_count++;
    endfunction

    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < q_count; k++) begin
            q_vals[k] = q_vals[k+1];
            q_pris[k] = q_pris[k+1];
        end
        q_count--;
    endfunction

    // compute the result word of one operation and advance the shadow queue
    function automatic t_out_word queue_step(t_in_word w);
        t_out_word r;
        int pos;
        r = '0;
        r.status = ST_OK;
        case (t_func'(w.func))
            FUNC_PUSH: begin
                if (q_count >= DEPTH) r.status = ST_FULL;
                else place_entry(w.value, w.priority_req);
            end
            FUNC_POP, FUNC_TOP: begin
                if (q_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.out_value = q_vals[0];
                    r.out_priority = q_pris[0];
                    if (w.func == FUNC_POP) drop_entry(0);
                end
            end
            default: begin
                pos = 0;
                while (pos < q_count && q_vals[pos] != w.value) pos++;
                if (pos >= q_count) begin
                    r.status = ST_NOT_FOUND;
                    r.old_priority = -1;
                end else begin
                    r.old_priority = q_pris[pos];
                    if (!outranks(w.priority_req, q_pris[pos])) begin
                        r.status = ST_NOT_HIGHER;
                    end else begin
                        drop_entry(pos);
                        place_entry(w.value, w.priority_req);
                    end
                end
            end
        endcase
        r.now_empty = (q_count == 0);
        return r;
    endfunction

    // directed table: word, whether a literal result is given, that result
    typedef struct {
        t_in_word word;
        bit       fixed;
        t_out_word result;
    } t_row;

    t_row directed_rows [$];

    function automatic t_in_word mk(t_func f, int v, int p);
        t_in_word w;
        w.func = f;
        w.value = v;
        w.priority_req = p;
        return w;
    endfunction

    function automatic t_out_word res(int ov, int op, int old, t_status s, bit e);
        t_out_word r;
        r.out_value = ov;
        r.out_priority = op;
        r.old_priority = old;
        r.status = s;
        r.now_empty = e;
        return r;
    endfunction

    function automatic void add_row(t_in_word w, bit fixed, t_out_word r);
        t_row row;
        row.word = w;
        row.fixed = fixed;
        row.result = r;
        directed_rows.push_back(row);
    endfunction

    // check result words as they are accepted
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_data);
            end else begin
                want = pending_results.pop_front();
                if (o_data.out_value !== want.out_value
                        || o_data.out_priority !== want.out_priority
                        || o_data.old_priority !== want.old_priority
                        || o_data.status !== want.status
                        || o_data.now_empty !== want.now_empty) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, o_data);
                end
            end
        end
    end

    // receiver: stall for a random stretch before each word
    always @(posedge i_clk) begin
        int wait_left;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            wait_left = 0;
        end else if (o_valid && !i_stall) begin
            wait_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            i_stall <= (wait_left != 0);
        end else if (wait_left > 0) begin
            wait_left--;
            i_stall <= (wait_left != 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // drop valid only when a gap follows, so back-to-back words keep it high
    task automatic send_word(t_in_word w, bit fixed, t_out_word r, bit bursty);
        int gap;
        t_out_word predicted;
        gap = bursty ? 0 : $urandom_range(0, 11);
        if (gap != 0) i_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
        i_data <= w;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predicted = queue_step(w);
        pending_results.push_back(fixed ? r : predicted);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_order(logic [1:0] mode);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {30'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        q_order = mode;
    endtask

    // random word; with a nonzero span, increases are biased toward values already in the queue
    function automatic t_in_word random_word(int value_span);
        t_in_word w;
        int pick;
        pick = $urandom_range(0, 99);
        w.func = (pick < 40) ? FUNC_PUSH : (pick < 60) ? FUNC_POP
               : (pick < 70) ? FUNC_TOP : FUNC_INC;
        if (value_span == 0) w.value = $urandom();
        else if (w.func == FUNC_INC && q_count > 0 && $urandom_range(0, 3) != 0)
            w.value = q_vals[$urandom_range(0, q_count - 1)];
        else w.value = $urandom_range(0, value_span) - value_span / 2;
        case ($urandom_range(0, 3))
            0: w.priority_req = $urandom();
            1: w.priority_req = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: w.priority_req = $urandom_range(0, 20) - 10;
        endcase
        return w;
    endfunction

    initial begin
        bit bursty;
        q_count = 0;
        q_order = ORD_LE;
        mismatches = 0;
        cycles = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, extremes, every operation and every error code
        add_row(mk(FUNC_POP, 0, 0), 1, res(0, 0, 0, ST_EMPTY, 1));
        add_row(mk(FUNC_TOP, 0, 0), 1, res(0, 0, 0, ST_EMPTY, 1));
        add_row(mk(FUNC_INC, 5, 0), 1, res(0, 0, -1, ST_NOT_FOUND, 1));
        add_row(mk(FUNC_PUSH, 32'h7fffffff, 32'h7fffffff), 1, res(0, 0, 0, ST_OK, 0));
        add_row(mk(FUNC_TOP, 0, 0), 1, res(32'h7fffffff, 32'h7fffffff, 0, ST_OK, 0));
        add_row(mk(FUNC_PUSH, 32'h80000000, 32'h80000000), 1, res(0, 0, 0, ST_OK, 0));
        add_row(mk(FUNC_TOP, 0, 0), 1,
                res(32'h80000000, 32'h80000000, 0, ST_OK, 0));
        add_row(mk(FUNC_INC, 32'h7fffffff, 32'h7fffffff), 0, '0);
        add_row(mk(FUNC_INC, 32'h7fffffff, 32'h80000000), 0, '0);
        add_row(mk(FUNC_INC, 32'h7fffffff, -3), 0, '0);
        for (int i = 0; i < 15; i++) add_row(mk(FUNC_PUSH, i, 15 - i), 0, '0);
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].fixed,
                      directed_rows[i].result, 1'b0);
        // queue is full now
        send_word(mk(FUNC_PUSH, -1, -1), 1, res(0, 0, 0, ST_FULL, 0), 1'b0);
        wait_idle();

        // random phases across every order relation
        for (int phase = 0; phase < 8; phase++) begin
            write_order(phase[1:0] ^ 2'd1);
            for (int n = 0; n < RANDOM_WORDS / 8; n++) begin
                bursty = (n % 50) < 8;
                send_word(random_word(phase == 7 ? 0 : 16), 1'b0, '0, bursty);
            end
            wait_idle();
        end

        all_sent = 1'b1;
        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/spq_chain.sv
rtl/core/sorted_priority_queue.sv
bench/sorted_priority_queue_test.sv
